### src/fp8cv_pkg.sv
// ----------------------------------------------------------------------------
// fp8cv_pkg
// Shared opcodes and constants for the FP8 E4M3 converter.
// ----------------------------------------------------------------------------
package fp8cv_pkg;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } opcode_t;

  localparam logic [7:0]  FP8_NAN    = 8'h7F;
  localparam logic [7:0]  FP8_INF    = 8'h78;
  localparam logic [63:0] F64_QNAN   = 64'h7FF8000000000000;
  localparam logic [63:0] F64_INF    = 64'h7FF0000000000000;
  localparam logic [10:0] F64_EXP_MAX = 11'h7FF;

endpackage

### src/fp8_e4m3_converter_core.sv
// ----------------------------------------------------------------------------
// fp8_e4m3_converter_core
// Converts binary64 to FP8 E4M3 (opcode 0) and FP8 E4M3 to binary64
// (opcode 1). Every request gives one result.
// ----------------------------------------------------------------------------
// One request per clock is accepted unless a stalled output holds the input
// register full. A request is captured in the input register; conversion
// logic feeds the result register, which presents the result at the output. Both registers advance
// whenever the stage behind them is free, so stalls on the output are
// absorbed without losing or repeating a request.
module fp8_e4m3_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [63:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_bits
);

  logic        s1_valid_r;
  logic        s1_op_r;
  logic [63:0] s1_bits_r;
  logic        out_valid_r;
  logic [63:0] out_bits_r;
  logic        s1_adv;
  logic        out_free;
  logic [63:0] res_nxt;

  // handshake flow
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  // encode
  logic [7:0]  enc;
  logic        sg;
  logic [10:0] bexp;
  logic [51:0] frac;
  logic [52:0] sig;
  logic [5:0]  sh;
  logic [3:0]  q;
  logic [3:0]  m;
  logic [4:0]  eb;
  always_comb begin
    sg   = s1_bits_r[63];
    bexp = s1_bits_r[62:52];
    frac = s1_bits_r[51:0];
    sig  = {1'b1, frac};
    sh   = '0;
    q    = '0;
    m    = '0;
    eb   = '0;
    enc  = {sg, 7'd0};
    if (bexp == fp8cv_pkg::F64_EXP_MAX) begin
      enc = (frac != '0) ? fp8cv_pkg::FP8_NAN : ({sg, 7'd0} | fp8cv_pkg::FP8_INF);
    end else if (bexp == '0) begin
      enc = {sg, 7'd0};
    end else if (bexp < 11'd1017) begin
      // tiny: round(sig >> (43-e)), shift 50..54
      if (bexp >= 11'd1012) begin
        sh = 6'(11'd1066 - bexp);
        q  = 4'(sig >> sh) + {3'd0, sig[6'(sh - 6'd1)]};
        if (q > 4'd7) q = 4'd7;
        enc = {sg, 4'd0, q[2:0]};
      end
    end else if (bexp > 11'd1030) begin
      enc = {sg, 7'd0} | fp8cv_pkg::FP8_INF;
    end else begin
      m  = {1'b0, frac[51:49]} + {3'd0, frac[48]};
      eb = 5'(bexp - 11'd1016);
      if (m[3]) eb = eb + 5'd1;
      if (eb >= 5'd15) enc = {sg, 7'd0} | fp8cv_pkg::FP8_INF;
      else             enc = {sg, eb[3:0], m[2:0]};
    end
  end

  // decode
  logic [63:0] dec;
  logic [7:0]  cd;
  always_comb begin
    cd  = s1_bits_r[7:0];
    dec = {cd[7], 63'd0};
    if (cd[6:3] == 4'd0) begin
      if (cd[2]) dec = {cd[7], 11'd1016, cd[1:0], 50'd0};
      else if (cd[1]) dec = {cd[7], 11'd1015, cd[0], 51'd0};
      else if (cd[0]) dec = {cd[7], 11'd1014, 52'd0};
    end else if (cd[6:3] == 4'hF) begin
      dec = {cd[7], 63'd0} | ((cd[2:0] == '0) ? fp8cv_pkg::F64_INF : fp8cv_pkg::F64_QNAN);
    end else begin
      dec = {cd[7], 11'({7'd0, cd[6:3]} + 11'd1016), cd[2:0], 49'd0};
    end
  end

  // result select
  always_comb begin
    case (fp8cv_pkg::opcode_t'(s1_op_r))
      fp8cv_pkg::OP_ENCODE: res_nxt = {56'd0, enc};
      fp8cv_pkg::OP_DECODE: res_nxt = dec;
      default:              res_nxt = dec;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (out_free) out_valid_r <= s1_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= in_opcode;
      s1_bits_r <= in_operand_bits;
    end
    if (s1_adv) out_bits_r <= res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_bits = out_bits_r;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_bits_r))
    else $error("result changed while stalled");
  // encode leaves upper bits clear
  a_enc: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_op_r |=> out_bits_r[63:8] == '0)
    else $error("encode upper bits set");
  // pending request is not dropped
  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r)
    else $error("stage lost request");

endmodule

### test/fp8_e4m3_converter_checker.sv
// ----------------------------------------------------------------------------
// fp8_e4m3_converter_checker
// Watches both channels of the FP8 E4M3 converter, predicts each result
// from the accepted request and compares it with what comes out, in order.
// ----------------------------------------------------------------------------
module fp8_e4m3_converter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_opcode,
  input  logic [63:0] in_operand_bits,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_result_bits,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] expected_results[$];

  // binary64 to fp8, integer only, half away from zero
  function automatic logic [63:0] to_fp8(input logic [63:0] x);
    logic [7:0]  sgn;
    logic [10:0] bexp;
    logic [51:0] frac;
    logic [52:0] sig;
    logic [63:0] q;
    logic [3:0]  m;
    int          e;
    int          sh;
    int          eb;
    sgn  = x[63] ? 8'h80 : 8'h00;
    bexp = x[62:52];
    frac = x[51:0];
    if (bexp == fp8cv_pkg::F64_EXP_MAX)
      return (frac != 0) ? 64'(fp8cv_pkg::FP8_NAN) : 64'(sgn | fp8cv_pkg::FP8_INF);
    if (bexp == 0) return 64'(sgn);
    e = int'(bexp) - 1023;
    // below the fp8 normal range: scale into the subnormal grid
    if (e < -6) begin
      sig = {1'b1, frac};
      sh = 43 - e;
      if (sh > 54) return 64'(sgn);
      q = 64'(sig >> sh);
      if (sig[sh-1]) q = q + 1;
      if (q > 7) q = 7;
      return 64'(sgn) | q;
    end
    if (e > 7) return 64'(sgn | fp8cv_pkg::FP8_INF);
    m = {1'b0, frac[51:49]};
    eb = e + 7;
    if (frac[48]) m = m + 1;
    if (m == 8) begin
      m = 0;
      eb = eb + 1;
    end
    if (eb >= 15) return 64'(sgn | fp8cv_pkg::FP8_INF);
    return 64'({sgn[7], eb[3:0], m[2:0]});
  endfunction

  // fp8 to binary64, exact
  function automatic logic [63:0] from_fp8(input logic [7:0] c);
    logic [63:0] sgn;
    logic [3:0]  eb;
    logic [2:0]  m;
    sgn = c[7] ? 64'h8000000000000000 : 64'h0;
    eb  = c[6:3];
    m   = c[2:0];
    if (eb == 0) begin
      if (m == 0) return sgn;
      if (m[2]) return sgn | {1'b0, 11'd1016, m[1:0], 50'd0};
      if (m[1]) return sgn | {1'b0, 11'd1015, m[0], 51'd0};
      return sgn | {1'b0, 11'd1014, 52'd0};
    end
    if (eb == 4'hF)
      return (m == 0) ? (sgn | fp8cv_pkg::F64_INF) : (sgn | fp8cv_pkg::F64_QNAN);
    return sgn | {1'b0, 11'(eb) + 11'd1016, m, 49'd0};
  endfunction

  // predict on each request, compare on each result
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
      pending_count <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(
          fp8cv_pkg::opcode_t'(in_opcode) == fp8cv_pkg::OP_ENCODE ?
          to_fp8(in_operand_bits) : from_fp8(in_operand_bits[7:0]));
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result_bits %h", $time, out_result_bits);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== out_result_bits) begin
            $display("%0t: result_bits expected %h actual %h", $time, want,
                     out_result_bits);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_results.size();
    end
  end
endmodule

### test/tb_fp8_e4m3_converter_core.sv
// ----------------------------------------------------------------------------
// tb_fp8_e4m3_converter_core
// Drives directed and random encode/decode requests into the converter with
// random gaps and back-pressure; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_fp8_e4m3_converter_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_opcode = 1'b0;
  logic [63:0] in_operand_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_result_bits;
  int          fail_count;
  int          pending_count;
  int          result_count;
  int          send_idle_pct = 8;
  int          recv_idle_pct = 86;
  bit          hold_off = 1'b0;
  int          idle_cycles = 0;
  int          request_count = 0;

  fp8_e4m3_converter_core u_dut (.*);

  fp8_e4m3_converter_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random, or holds off for a long stretch
  always @(negedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAIL fp8_e4m3_converter_core");
      $finish;
    end
  end

  // offer one request and wait for its acceptance
  task automatic send_request(input fp8cv_pkg::opcode_t op, input logic [63:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_operand_bits <= bits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    request_count++;
    @(negedge clk);
  endtask

  // binary64 operand weighted toward the fp8 range and its edges
  function automatic logic [63:0] pick_f64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1: ;
      2: v[62:52] = $urandom_range(1) ? 11'h7FF : 11'h000;
      default: v[62:52] = 11'($urandom_range(1031, 1013));
    endcase
    if ($urandom_range(3) == 0) v[47:0] = $urandom_range(1) ? '0 : '1;
    return v;
  endfunction

  task automatic run_random(input int count);
    logic [63:0] v;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1)) send_request(fp8cv_pkg::OP_ENCODE, pick_f64());
      else begin
        v = {$urandom, $urandom};
        send_request(fp8cv_pkg::OP_DECODE, v);
      end
    end
  endtask

  initial begin
    logic [63:0] directed[$];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: nan, infinities, zeros, subnormal range, rounding, overflow
    directed = '{64'h7FF8000000000001, 64'hFFF0000000000001, 64'h7FF0000000000000,
      64'hFFF0000000000000, 64'h0000000000000000, 64'h8000000000000000,
      64'h000FFFFFFFFFFFFF, 64'h3F50000000000000, 64'h3F60000000000000,
      64'hBF8C000000000000, 64'h3F90000000000000, 64'h3FF1000000000000,
      64'h3FFF000000000000, 64'h406E000000000000, 64'h406F000000000000,
      64'h4070000000000000, 64'hFFEFFFFFFFFFFFFF, 64'h3F4FFFFFFFFFFFFF};
    foreach (directed[i]) send_request(fp8cv_pkg::OP_ENCODE, directed[i]);
    send_request(fp8cv_pkg::OP_DECODE, 64'hFFFF_FFFF_FFFF_FF80);
    send_request(fp8cv_pkg::OP_DECODE, 64'h0000_0000_0000_0001);
    send_request(fp8cv_pkg::OP_DECODE, 64'h0000_0000_0000_0007);
    send_request(fp8cv_pkg::OP_DECODE, 64'h0000_0000_0000_0078);
    send_request(fp8cv_pkg::OP_DECODE, 64'h0000_0000_0000_00FF);
    send_request(fp8cv_pkg::OP_DECODE, 64'h0000_0000_0000_0077);

    // every fp8 code once
    for (int c = 0; c < 256; c++)
      send_request(fp8cv_pkg::OP_DECODE, ({$urandom, $urandom} & ~64'hFF) | 64'(c));

    run_random(450);

    // receiver blocked while requests keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (60) @(negedge clk);
        hold_off = 1'b0;
      end
      run_random(20);
    join

    send_idle_pct = 86;
    recv_idle_pct = 8;
    run_random(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(500);
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d requests and %0d results: all fp8 codes, encode specials,",
             request_count, result_count);
    $display("rounding edges, random binary64 operands, stalls on both sides, a full back-up");
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS fp8_e4m3_converter_core");
    end else begin
      $display("FAIL fp8_e4m3_converter_core");
    end
    $finish;
  end
endmodule

### sim.f
src/fp8cv_pkg.sv
src/fp8_e4m3_converter_core.sv
test/fp8_e4m3_converter_checker.sv
test/tb_fp8_e4m3_converter_core.sv
